FILE: src/ctp_pkg.sv
package ctp_pkg;

  localparam int CTP_COUNT_BITS = 32;
  localparam int CTP_EDGE_LIMIT = 16384;

  localparam int CTP_CFG_W    = 32;
  localparam int CTP_IDX_W    = 3;
  localparam int CTP_EDGE_W   = 15;
  localparam int CTP_BYTES_W  = 9;
  localparam int CTP_OFFSET_W = 32;
  localparam int CTP_DIM_W    = 15;
  localparam int CTP_LEN_W    = 29;

  localparam logic [CTP_IDX_W-1:0] REG_TUPLE_COUNT   = 3'd0;
  localparam logic [CTP_IDX_W-1:0] REG_MAX_EDGE      = 3'd1;
  localparam logic [CTP_IDX_W-1:0] REG_TUPLE_BYTES   = 3'd2;
  localparam logic [CTP_IDX_W-1:0] REG_MEMORY_BUDGET = 3'd3;
  localparam logic [CTP_IDX_W-1:0] REG_TUPLE_CAP     = 3'd4;

  localparam logic [CTP_EDGE_W-1:0] MAX_EDGE_RST      = 15'd64;
  localparam logic [CTP_CFG_W-1:0]  MEMORY_BUDGET_RST = 32'(128 * 1024 * 1024);

  typedef logic [3:0] ctp_op_t;

  localparam ctp_op_t OP_NONE    = 4'd0;
  localparam ctp_op_t OP_SQUARE  = 4'd1;
  localparam ctp_op_t OP_PRODUCT = 4'd2;
  localparam ctp_op_t OP_RATIO   = 4'd3;
  localparam ctp_op_t OP_ONE     = 4'd4;
  localparam ctp_op_t OP_SCALE   = 4'd5;
  localparam ctp_op_t OP_CAP     = 4'd6;
  localparam ctp_op_t OP_SMALL   = 4'd7;
  localparam ctp_op_t OP_ROWS    = 4'd8;
  localparam ctp_op_t OP_HEIGHT  = 4'd9;
  localparam ctp_op_t OP_MIDROWS = 4'd10;
  localparam ctp_op_t OP_MIDSTEP = 4'd11;
  localparam ctp_op_t OP_MIDCUR  = 4'd12;

  typedef logic [2:0] ctp_div_sel_t;

  localparam ctp_div_sel_t DIV_RATIO   = 3'd0;
  localparam ctp_div_sel_t DIV_SCALE   = 3'd1;
  localparam ctp_div_sel_t DIV_SMALL   = 3'd2;
  localparam ctp_div_sel_t DIV_ROWS    = 3'd3;
  localparam ctp_div_sel_t DIV_HEIGHT  = 3'd4;
  localparam ctp_div_sel_t DIV_MIDROWS = 3'd5;

  typedef struct packed {
    ctp_op_t      op;
    logic         div_start;
    ctp_div_sel_t div_sel;
    logic         commit;
    logic         restart;
  } ctp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic budget_zero;
    logic ratio_big;
    logic ratio_over;
    logic narrow;
  } ctp_status_t;

endpackage

FILE: src/ctp_div.sv
module ctp_div
  import ctp_pkg::*;
#(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             fin;
  logic [W:0]       part;
  logic [W:0]       diff;

  assign part = {rem, quo[W-1]};
  assign diff = part - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= part[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign done      = fin;

endmodule

FILE: src/ctp_dp.sv
module ctp_dp
  import ctp_pkg::*;
#(
  parameter int COUNT_BITS = CTP_COUNT_BITS,
  parameter int EDGE_LIMIT = CTP_EDGE_LIMIT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CTP_IDX_W-1:0]    cfg_index,
  input  logic [CTP_CFG_W-1:0]    cfg_data,
  input  ctp_cmd_t                cmd,
  output ctp_status_t             sts,
  output logic [CTP_OFFSET_W-1:0] chunk_offset,
  output logic [CTP_DIM_W-1:0]    chunk_width,
  output logic [CTP_DIM_W-1:0]    chunk_height,
  output logic [CTP_LEN_W-1:0]    chunk_length,
  output logic                    done_res,
  output logic                    misuse
);

  localparam int CB  = COUNT_BITS;
  localparam int EW  = $clog2(EDGE_LIMIT + 1);
  localparam int MW  = 2 * EW;
  localparam int PW  = MW + CTP_BYTES_W;
  localparam int DA  = (CB > PW) ? CB : PW;
  localparam int DW  = (DA > CTP_CFG_W) ? DA : CTP_CFG_W;
  localparam int CW  = (MW > CTP_CFG_W) ? MW : CTP_CFG_W;
  localparam int XW  = 17;
  localparam logic [XW-1:0] LIM = XW'(EDGE_LIMIT);

  logic [CTP_CFG_W-1:0]   tuple_count;
  logic [CTP_EDGE_W-1:0]  max_edge;
  logic [CTP_BYTES_W-1:0] tuple_bytes;
  logic [CTP_CFG_W-1:0]   memory_budget;
  logic [CTP_CFG_W-1:0]   tuple_cap;

  logic [CB-1:0] cursor;
  logic [CB-1:0] step;
  logic [CB-1:0] mid_cursor;
  logic [CB-1:0] mid_step;
  logic [EW-1:0] mid_rows;
  logic [CB-1:0] tail_cursor;
  logic [EW-1:0] tail_step;
  logic [EW-1:0] cur_width;
  logic [EW-1:0] cur_height;

  logic [MW-1:0] mstep;
  logic [PW-1:0] prod;
  logic [PW-1:0] ratio;
  logic [CB-1:0] rows;
  logic [EW-1:0] height;
  logic [CB-1:0] first_step;

  logic [CTP_OFFSET_W-1:0] out_offset;
  logic [CTP_DIM_W-1:0]    out_w;
  logic [CTP_DIM_W-1:0]    out_h;
  logic                    out_done;
  logic                    out_bad;

  logic [XW-1:0] edge_x;
  logic [XW-1:0] edge_c;
  logic [EW-1:0] edge_len;
  logic [CB-1:0] size;

  logic [DW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic [DW-1:0] quot;
  logic [DW-1:0] rem;
  logic          div_done;

  logic          done_now;
  logic          bad;
  logic [CB-1:0] ncur;
  logic          ndone;
  logic [CB-1:0] nstep;
  logic [EW-1:0] nw;
  logic [EW-1:0] nh;

  assign edge_x   = XW'(max_edge);
  assign edge_c   = (edge_x == '0) ? XW'(1) : ((edge_x > LIM) ? LIM : edge_x);
  assign edge_len = EW'(edge_c);
  assign size     = CB'(tuple_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tuple_count   <= '0;
      max_edge      <= MAX_EDGE_RST;
      tuple_bytes   <= CTP_BYTES_W'(1);
      memory_budget <= MEMORY_BUDGET_RST;
      tuple_cap     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TUPLE_COUNT:   tuple_count   <= cfg_data;
        REG_MAX_EDGE:      max_edge      <= cfg_data[CTP_EDGE_W-1:0];
        REG_TUPLE_BYTES:   tuple_bytes   <= cfg_data[CTP_BYTES_W-1:0];
        REG_MEMORY_BUDGET: memory_budget <= cfg_data;
        REG_TUPLE_CAP:     tuple_cap     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_RATIO: begin
        div_a = DW'(prod);
        div_b = DW'(memory_budget);
      end
      DIV_SCALE: begin
        div_a = DW'(mstep);
        div_b = DW'(ratio);
      end
      DIV_SMALL: begin
        div_a = DW'(size);
        div_b = DW'(mstep);
      end
      DIV_ROWS: begin
        div_a = DW'(size);
        div_b = DW'(edge_len);
      end
      DIV_HEIGHT: begin
        div_a = DW'(mstep);
        div_b = DW'(edge_len);
      end
      DIV_MIDROWS: begin
        div_a = DW'(rows);
        div_b = DW'(height);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  ctp_div #(
    .W (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (quot),
    .remainder (rem),
    .done      (div_done)
  );

  always_comb begin
    done_now = cursor >= size;
    bad      = !cmd.restart && done_now;
    if (cmd.restart) begin
      ncur = '0;
    end else if (done_now) begin
      ncur = cursor;
    end else begin
      ncur = cursor + step;
    end
    ndone = ncur >= size;
    nstep = cmd.restart ? first_step : step;
    nw    = cur_width;
    nh    = cur_height;
    if (!ndone) begin
      if (ncur == tail_cursor) begin
        nw    = tail_step;
        nh    = EW'(1);
        nstep = CB'(tail_step);
      end else if (ncur == mid_cursor) begin
        nw    = edge_len;
        nh    = mid_rows;
        nstep = mid_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      step        <= '0;
      mid_cursor  <= '0;
      mid_step    <= '0;
      mid_rows    <= '0;
      tail_cursor <= '0;
      tail_step   <= '0;
      cur_width   <= '0;
      cur_height  <= '0;
    end else if (cmd.commit) begin
      cursor     <= ncur;
      step       <= nstep;
      cur_width  <= nw;
      cur_height <= nh;
    end else begin
      case (cmd.op)
        OP_SMALL: begin
          tail_step   <= EW'(rem);
          tail_cursor <= size - CB'(rem);
          mid_cursor  <= size - CB'(rem);
          cur_width   <= EW'(mstep);
          cur_height  <= EW'(1);
          mid_step    <= '0;
          mid_rows    <= '0;
        end
        OP_ROWS: begin
          tail_step   <= EW'(rem);
          tail_cursor <= size - CB'(rem);
          cur_width   <= edge_len;
          cur_height  <= EW'(1);
          mid_cursor  <= '0;
          mid_step    <= '0;
          mid_rows    <= '0;
        end
        OP_HEIGHT:  cur_height <= EW'(quot);
        OP_MIDROWS: mid_rows   <= EW'(rem);
        OP_MIDSTEP: mid_step   <= CB'(MW'(edge_len) * MW'(mid_rows));
        OP_MIDCUR:  mid_cursor <= tail_cursor - mid_step;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQUARE:  mstep <= MW'(edge_len) * MW'(edge_len);
      OP_PRODUCT: prod  <= PW'(mstep) * PW'(tuple_bytes);
      OP_RATIO:   ratio <= PW'(quot);
      OP_ONE:     mstep <= MW'(1);
      OP_SCALE:   mstep <= MW'(quot);
      OP_CAP: begin
        if (tuple_cap != '0 && CW'(mstep) > CW'(tuple_cap)) begin
          mstep <= MW'(tuple_cap);
        end
      end
      OP_SMALL:   first_step <= CB'(mstep);
      OP_ROWS: begin
        rows       <= CB'(quot);
        first_step <= '0;
      end
      OP_HEIGHT:  height <= EW'(quot);
      OP_MIDROWS: first_step <= CB'(MW'(edge_len) * MW'(height));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_offset <= CTP_OFFSET_W'(ncur);
      out_w      <= ndone ? '0 : CTP_DIM_W'(nw);
      out_h      <= ndone ? '0 : CTP_DIM_W'(nh);
      out_done   <= ndone;
      out_bad    <= bad;
    end
  end

  assign sts.div_done    = div_done;
  assign sts.quot_zero   = quot == '0;
  assign sts.budget_zero = memory_budget == '0;
  assign sts.ratio_big   = ratio > PW'(1) && mstep > MW'(1);
  assign sts.ratio_over  = ratio > PW'(mstep);
  assign sts.narrow      = mstep < MW'(edge_len);

  assign chunk_offset = out_offset;
  assign chunk_width  = out_w;
  assign chunk_height = out_h;
  assign chunk_length = CTP_LEN_W'(30'(out_w) * 30'(out_h));
  assign done_res     = out_done;
  assign misuse       = out_bad;

endmodule

FILE: src/ctp_ctrl.sv
module ctp_ctrl
  import ctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  input  ctp_status_t sts,
  output ctp_cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE         = 5'd0;
  localparam logic [4:0] ST_ADV          = 5'd1;
  localparam logic [4:0] ST_SQUARE       = 5'd2;
  localparam logic [4:0] ST_PRODUCT      = 5'd3;
  localparam logic [4:0] ST_RATIO_GO     = 5'd4;
  localparam logic [4:0] ST_RATIO_WAIT   = 5'd5;
  localparam logic [4:0] ST_SCALE_CHK    = 5'd6;
  localparam logic [4:0] ST_SCALE_GO     = 5'd7;
  localparam logic [4:0] ST_SCALE_WAIT   = 5'd8;
  localparam logic [4:0] ST_CAP          = 5'd9;
  localparam logic [4:0] ST_SPLIT_GO     = 5'd10;
  localparam logic [4:0] ST_SPLIT_WAIT   = 5'd11;
  localparam logic [4:0] ST_HEIGHT_GO    = 5'd12;
  localparam logic [4:0] ST_HEIGHT_WAIT  = 5'd13;
  localparam logic [4:0] ST_MIDROWS_GO   = 5'd14;
  localparam logic [4:0] ST_MIDROWS_WAIT = 5'd15;
  localparam logic [4:0] ST_MIDSTEP      = 5'd16;
  localparam logic [4:0] ST_MIDCUR       = 5'd17;
  localparam logic [4:0] ST_COMMIT       = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = state != ST_IDLE;

  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_RATIO;
    cmd.commit    = 1'b0;
    cmd.restart   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = restart ? ST_SQUARE : ST_ADV;
        end
      end
      ST_ADV: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SQUARE: begin
        cmd.op     = OP_SQUARE;
        state_next = ST_PRODUCT;
      end
      ST_PRODUCT: begin
        cmd.op     = OP_PRODUCT;
        state_next = sts.budget_zero ? ST_CAP : ST_RATIO_GO;
      end
      ST_RATIO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATIO;
        state_next    = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = OP_RATIO;
          state_next = ST_SCALE_CHK;
        end
      end
      ST_SCALE_CHK: begin
        if (sts.ratio_big && sts.ratio_over) begin
          cmd.op     = OP_ONE;
          state_next = ST_CAP;
        end else if (sts.ratio_big) begin
          state_next = ST_SCALE_GO;
        end else begin
          state_next = ST_CAP;
        end
      end
      ST_SCALE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SCALE;
        state_next    = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = OP_SCALE;
          state_next = ST_CAP;
        end
      end
      ST_CAP: begin
        cmd.op     = OP_CAP;
        state_next = ST_SPLIT_GO;
      end
      ST_SPLIT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = sts.narrow ? DIV_SMALL : DIV_ROWS;
        state_next    = ST_SPLIT_WAIT;
      end
      ST_SPLIT_WAIT: begin
        if (sts.div_done) begin
          if (sts.narrow) begin
            cmd.op     = OP_SMALL;
            state_next = ST_COMMIT;
          end else begin
            cmd.op     = OP_ROWS;
            state_next = sts.quot_zero ? ST_COMMIT : ST_HEIGHT_GO;
          end
        end
      end
      ST_HEIGHT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HEIGHT;
        state_next    = ST_HEIGHT_WAIT;
      end
      ST_HEIGHT_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = OP_HEIGHT;
          state_next = ST_MIDROWS_GO;
        end
      end
      ST_MIDROWS_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MIDROWS;
        state_next    = ST_MIDROWS_WAIT;
      end
      ST_MIDROWS_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = OP_MIDROWS;
          state_next = ST_MIDSTEP;
        end
      end
      ST_MIDSTEP: begin
        cmd.op     = OP_MIDSTEP;
        state_next = ST_MIDCUR;
      end
      ST_MIDCUR: begin
        cmd.op     = OP_MIDCUR;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd.commit  = 1'b1;
          cmd.restart = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.commit || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: src/texture_chunk_tiler_top.sv
// Channel   Handshake                Payload
// input     in_valid / in_stall      restart
// output    out_valid / out_stall    chunk_offset, chunk_width, chunk_height,
//                                    chunk_length, done_res, misuse
// config    cfg_we                   cfg_index, cfg_data
//
// An advance item is accepted in the idle state and steps the cursor in the advance state.
// A restart item runs up to five divisions on the shared one-bit-per-cycle divider.
// Reset is synchronous and restores the register defaults and an empty plan.
// A new item is accepted while an earlier result still waits in the output register;
// a stalled output holds its transfer and delays the next result and the items after it.
module texture_chunk_tiler_top
  import ctp_pkg::*;
#(
  parameter int COUNT_BITS = CTP_COUNT_BITS,
  parameter int EDGE_LIMIT = CTP_EDGE_LIMIT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CTP_OFFSET_W-1:0] chunk_offset,
  output logic [CTP_DIM_W-1:0]    chunk_width,
  output logic [CTP_DIM_W-1:0]    chunk_height,
  output logic [CTP_LEN_W-1:0]    chunk_length,
  output logic                    done_res,
  output logic                    misuse,
  input  logic                    cfg_we,
  input  logic [CTP_IDX_W-1:0]    cfg_index,
  input  logic [CTP_CFG_W-1:0]    cfg_data
);

  ctp_cmd_t    cmd;
  ctp_status_t sts;

  ctp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctp_dp #(
    .COUNT_BITS (COUNT_BITS),
    .EDGE_LIMIT (EDGE_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .chunk_offset (chunk_offset),
    .chunk_width  (chunk_width),
    .chunk_height (chunk_height),
    .chunk_length (chunk_length),
    .done_res     (done_res),
    .misuse       (misuse)
  );

endmodule

FILE: src/ctp_chk.sv
module ctp_chk
  import ctp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [CTP_OFFSET_W-1:0] chunk_offset,
  input logic [CTP_DIM_W-1:0]    chunk_width,
  input logic [CTP_DIM_W-1:0]    chunk_height,
  input logic [CTP_LEN_W-1:0]    chunk_length,
  input logic                    done_res,
  input logic                    misuse
);

  a_misuse_done : assert property (@(posedge clk) disable iff (rst)
    out_valid && misuse |-> done_res)
    else $error("misuse reported on a chunk that is not done");

  a_done_empty : assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |->
      chunk_width == '0 && chunk_height == '0 && chunk_length == '0)
    else $error("finished cursor reports a non-empty chunk");

  a_length : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chunk_length == CTP_LEN_W'(30'(chunk_width) * 30'(chunk_height)))
    else $error("chunk length differs from width times height");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted before the first was processed");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chunk_offset) && $stable(done_res))
    else $error("stalled result transfer changed");

endmodule

bind texture_chunk_tiler_top ctp_chk u_chk (.*);

FILE: tb/sv/texture_chunk_tiler_top_tb.sv
`timescale 1ns / 100ps

module texture_chunk_tiler_top_tb;
  import ctp_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [CTP_OFFSET_W-1:0] offset;
    logic [CTP_DIM_W-1:0]    width;
    logic [CTP_DIM_W-1:0]    height;
    logic [CTP_LEN_W-1:0]    length;
    logic                    done;
    logic                    misuse;
  } chunk_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CTP_IDX_W-1:0] idx;
    logic [CTP_CFG_W-1:0] data;
    logic                 rs;
    int                   reps;
    logic                 known;
    chunk_t               want;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    restart;
  logic                    out_valid;
  logic                    out_stall;
  logic [CTP_OFFSET_W-1:0] chunk_offset;
  logic [CTP_DIM_W-1:0]    chunk_width;
  logic [CTP_DIM_W-1:0]    chunk_height;
  logic [CTP_LEN_W-1:0]    chunk_length;
  logic                    done_res;
  logic                    misuse;
  logic                    cfg_we;
  logic [CTP_IDX_W-1:0]    cfg_index;
  logic [CTP_CFG_W-1:0]    cfg_data;

  texture_chunk_tiler_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies and tiling state of the predictor.
  logic [31:0] tuples_total;
  logic [14:0] edge_reg;
  logic [8:0]  bytes_per_tuple;
  logic [31:0] byte_budget;
  logic [31:0] tuples_cap;
  logic [63:0] pos, pos_step, mid_pos, mid_len, mid_rows_n;
  logic [63:0] tail_pos, tail_len, w_now, h_now;

  chunk_t      chunk_q[$];
  script_row_t script[$];
  int          errors = 0;
  int          items_sent = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          cycle_count = 0;
  logic        quiet = 1'b0;

  function automatic logic [63:0] clamped_edge();
    logic [63:0] e;
    e = {49'd0, edge_reg};
    if (e == 0) e = 1;
    if (e > CTP_EDGE_LIMIT) e = CTP_EDGE_LIMIT;
    return e;
  endfunction

  function automatic logic past_end();
    return pos >= {32'd0, tuples_total};
  endfunction

  function automatic logic [63:0] chunk_limit();
    logic [63:0] e, lim, ratio;
    e = clamped_edge();
    lim = e * e;
    if (byte_budget != 0) begin
      ratio = (lim * {55'd0, bytes_per_tuple}) / {32'd0, byte_budget};
      if (ratio > 1 && lim > 1) begin
        if (ratio > lim) lim = 1;
        else lim = lim / ratio;
      end
    end
    if (tuples_cap != 0 && lim > {32'd0, tuples_cap}) lim = {32'd0, tuples_cap};
    return lim;
  endfunction

  function automatic void load_dims();
    if (pos == tail_pos) begin
      w_now = tail_len;
      h_now = 1;
      pos_step = tail_len;
    end else if (pos == mid_pos) begin
      w_now = clamped_edge();
      h_now = mid_rows_n;
      pos_step = mid_len;
    end
  endfunction

  function automatic void plan_chunks();
    logic [63:0] e, lim, total, first, rows, rows_per;
    e = clamped_edge();
    lim = chunk_limit();
    total = {32'd0, tuples_total};
    if (lim < e) begin
      first = lim;
      tail_pos = (total / lim) * lim;
      tail_len = total % lim;
      w_now = lim;
      h_now = 1;
      mid_pos = tail_pos;
      mid_len = 0;
      mid_rows_n = 0;
    end else begin
      rows = total / e;
      w_now = e;
      tail_len = total % e;
      if (rows > 0) begin
        rows_per = lim / e;
        mid_rows_n = rows % rows_per;
        first = e * rows_per;
        mid_pos = (rows / rows_per) * first;
        mid_len = e * mid_rows_n;
        h_now = rows_per;
      end else begin
        first = 0;
        mid_pos = 0;
        mid_len = 0;
        mid_rows_n = 0;
        h_now = 1;
      end
      tail_pos = mid_pos + mid_len;
    end
    pos = 0;
    pos_step = first;
    if (!past_end()) load_dims();
  endfunction

  function automatic chunk_t next_chunk(input logic rs);
    chunk_t      c;
    logic        bad;
    logic [63:0] w, h;
    bad = 1'b0;
    if (rs) begin
      plan_chunks();
    end else if (past_end()) begin
      bad = 1'b1;
    end else begin
      pos = (pos + pos_step) & 64'hFFFF_FFFF;
      if (!past_end()) load_dims();
    end
    w = past_end() ? 64'd0 : {49'd0, w_now[14:0]};
    h = past_end() ? 64'd0 : {49'd0, h_now[14:0]};
    c.offset = pos[31:0];
    c.width = w[14:0];
    c.height = h[14:0];
    c.length = CTP_LEN_W'(w * h);
    c.done = past_end();
    c.misuse = bad;
    return c;
  endfunction

  function automatic void put_write(input logic [CTP_IDX_W-1:0] idx,
                                    input logic [CTP_CFG_W-1:0] val);
    script_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = val;
    r.rs = 1'b0;
    r.reps = 0;
    r.known = 1'b0;
    r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void put_item(input logic rs, input int reps);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.idx = REG_TUPLE_COUNT;
    r.data = '0;
    r.rs = rs;
    r.reps = reps;
    r.known = 1'b0;
    r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void put_known(input logic rs, input logic [31:0] off,
                                    input logic [14:0] w, input logic [14:0] h,
                                    input logic [28:0] len, input logic dn,
                                    input logic bad);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.idx = REG_TUPLE_COUNT;
    r.data = '0;
    r.rs = rs;
    r.reps = 1;
    r.known = 1'b1;
    r.want = '{off, w, h, len, dn, bad};
    script.push_back(r);
  endfunction

  task automatic cfg_write(input logic [CTP_IDX_W-1:0] idx, input logic [CTP_CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TUPLE_COUNT:   tuples_total = val;
      REG_MAX_EDGE:      edge_reg = val[14:0];
      REG_TUPLE_BYTES:   bytes_per_tuple = val[8:0];
      REG_MEMORY_BUDGET: byte_budget = val;
      REG_TUPLE_CAP:     tuples_cap = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic rs, input logic known, input chunk_t want);
    chunk_t c;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    c = next_chunk(rs);
    chunk_q.push_back(known ? want : c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_setup();
    logic [63:0] ee, lim, top;
    int          pick;
    pick = $urandom_range(0, 9);
    cfg_write(REG_MAX_EDGE, pick == 0 ? 32'd0 : pick == 1 ? $urandom_range(16385, 32767) :
                            pick == 2 ? 32'd16384 : $urandom_range(1, 48));
    ee = clamped_edge();
    cfg_write(REG_TUPLE_BYTES, $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) :
                               $urandom_range(1, 4));
    pick = $urandom_range(0, 9);
    if (pick < 3) cfg_write(REG_MEMORY_BUDGET, 32'd0);
    else if (pick == 3) cfg_write(REG_MEMORY_BUDGET, 32'hFFFF_FFFF);
    else if (pick == 4) cfg_write(REG_MEMORY_BUDGET, $urandom);
    else if (pick == 5) cfg_write(REG_MEMORY_BUDGET, 32'd1);
    else cfg_write(REG_MEMORY_BUDGET,
                   32'((ee * ee * {55'd0, bytes_per_tuple}) / $urandom_range(1, 64)));
    pick = $urandom_range(0, 9);
    if (pick < 5) cfg_write(REG_TUPLE_CAP, 32'd0);
    else if (pick < 7) cfg_write(REG_TUPLE_CAP, $urandom_range(1, 100));
    else if (pick == 7) cfg_write(REG_TUPLE_CAP, $urandom);
    else cfg_write(REG_TUPLE_CAP, $urandom_range(1, 32'(ee * ee)));
    lim = chunk_limit();
    top = lim * $urandom_range(1, 12) + ee;
    if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
    pick = $urandom_range(0, 19);
    if (pick == 0) cfg_write(REG_TUPLE_COUNT, 32'hFFFF_FFFF);
    else if (pick < 3) cfg_write(REG_TUPLE_COUNT, $urandom);
    else cfg_write(REG_TUPLE_COUNT, $urandom_range(0, 32'(top)));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    chunk_t want;
    if (!rst && out_valid && !out_stall) begin
      if (chunk_q.size() == 0) begin
        errors++;
        $error("result with no expectation waiting: chunk_offset %h", chunk_offset);
      end else begin
        want = chunk_q.pop_front();
        if (chunk_offset !== want.offset) begin
          errors++;
          $error("chunk_offset: expected %h, got %h", want.offset, chunk_offset);
        end
        if (chunk_width !== want.width) begin
          errors++;
          $error("chunk_width: expected %0d, got %0d", want.width, chunk_width);
        end
        if (chunk_height !== want.height) begin
          errors++;
          $error("chunk_height: expected %0d, got %0d", want.height, chunk_height);
        end
        if (chunk_length !== want.length) begin
          errors++;
          $error("chunk_length: expected %0d, got %0d", want.length, chunk_length);
        end
        if (done_res !== want.done) begin
          errors++;
          $error("done_res: expected %b, got %b", want.done, done_res);
        end
        if (misuse !== want.misuse) begin
          errors++;
          $error("misuse: expected %b, got %b", want.misuse, misuse);
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int phase;
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TUPLE_COUNT;
    cfg_data = '0;
    tuples_total = 32'd0;
    edge_reg = MAX_EDGE_RST;
    bytes_per_tuple = 9'd1;
    byte_budget = MEMORY_BUDGET_RST;
    tuples_cap = 32'd0;
    {pos, pos_step, mid_pos, mid_len, mid_rows_n} = '0;
    {tail_pos, tail_len, w_now, h_now} = '0;

    put_known(1'b0, 32'd0, 15'd0, 15'd0, 29'd0, 1'b1, 1'b1);
    put_known(1'b1, 32'd0, 15'd0, 15'd0, 29'd0, 1'b1, 1'b0);
    put_write(REG_TUPLE_COUNT, 32'd100);
    put_item(1'b0, 1);
    put_item(1'b1, 1);
    put_item(1'b0, 2);
    put_write(REG_MAX_EDGE, 32'd0);
    put_write(REG_TUPLE_COUNT, 32'd3);
    put_known(1'b1, 32'd0, 15'd1, 15'd1, 29'd1, 1'b0, 1'b0);
    put_write(REG_MAX_EDGE, 32'd64);
    put_write(REG_TUPLE_BYTES, 32'd256);
    put_write(REG_MEMORY_BUDGET, 32'd1);
    put_write(REG_TUPLE_COUNT, 32'd5);
    put_known(1'b1, 32'd0, 15'd1, 15'd1, 29'd1, 1'b0, 1'b0);
    put_write(REG_TUPLE_BYTES, 32'd0);
    put_write(REG_MEMORY_BUDGET, 32'd0);
    put_write(REG_TUPLE_CAP, 32'd10);
    put_write(REG_TUPLE_COUNT, 32'd25);
    put_item(1'b1, 1);
    put_item(1'b0, 2);
    put_write(REG_MAX_EDGE, 32'd32767);
    put_write(REG_TUPLE_BYTES, 32'd511);
    put_write(REG_MEMORY_BUDGET, 32'hFFFF_FFFF);
    put_write(REG_TUPLE_CAP, 32'hFFFF_FFFF);
    put_write(REG_TUPLE_COUNT, 32'hFFFF_FFFF);
    put_item(1'b1, 1);
    // A full-size plan is walked to its end; raising the count afterwards makes the
    // stale step carry the cursor past the top of its range.
    put_write(REG_MEMORY_BUDGET, 32'd0);
    put_write(REG_TUPLE_CAP, 32'd0);
    put_write(REG_TUPLE_COUNT, 32'hFFFF_0000);
    put_item(1'b1, 1);
    put_item(1'b0, 16);
    put_write(REG_TUPLE_COUNT, 32'hFFFF_FFFF);
    put_item(1'b0, 2);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        cfg_write(script[i].idx, script[i].data);
      end else begin
        repeat (script[i].reps) send_item(script[i].rs, script[i].known, script[i].want);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - 60) quiet = 1'b1;
      random_setup();
      if ($urandom_range(0, 9) != 0) send_item(1'b1, 1'b0, '0);
      if (phase == 2) begin
        hold_req++;
        repeat (30) send_item(1'b0, 1'b0, '0);
      end
      for (k = 0; k < 40; k++) begin
        send_item($urandom_range(0, 11) == 0, 1'b0, '0);
        if (past_end() && $urandom_range(0, 2) != 0) break;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ctp_pkg.sv
src/ctp_div.sv
src/ctp_dp.sv
src/ctp_ctrl.sv
src/texture_chunk_tiler_top.sv
src/ctp_chk.sv
tb/sv/texture_chunk_tiler_top_tb.sv
